// ----- sv/bcte_pkg.sv -----
// Package for the battery charge trend estimator.
// Holds field widths, the charge limit, register indexes and result codes.
// No dependencies.
package bcte_pkg;

  localparam int HistoryDepthDefault = 6;

  localparam int VoltW  = 12;
  localparam int ChargeW = 15;
  localparam int ConfW  = 7;

  localparam int InDataW  = 32;
  localparam int OutDataW = 40;
  localparam int CfgDataW = 15;

  localparam logic [ChargeW-1:0] ChargeFullQ8 = 15'd25600;

  localparam logic [ConfW-1:0] ConfUnknown     = 7'd20;
  localparam logic [ConfW-1:0] ConfCharging    = 7'd70;
  localparam logic [ConfW-1:0] ConfNotCharging = 7'd60;
  localparam logic [ConfW-1:0] ConfNone        = 7'd0;

  localparam logic RegSocRiseThr  = 1'b0;
  localparam logic RegVoltRiseThr = 1'b1;

  typedef enum logic [1:0] {
    StateUnknown     = 2'd0,
    StateCharging    = 2'd1,
    StateNotCharging = 2'd2
  } trend_code_t;

endpackage

// ----- sv/battery_charge_trend_estimator.sv -----
// An accepted request's result appears in the output register in the next cycle.
// Throughput: one request per cycle while results are taken; s_tready = !m_tvalid |
// m_tready, so the output register is refilled in the cycle its result is taken.
// Reset (rst, synchronous): empties the history (fill count and slot to zero),
// drops the output request, restores threshold defaults 38 and 12.
module battery_charge_trend_estimator #(
  parameter int HISTORY_DEPTH = bcte_pkg::HistoryDepthDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bcte_pkg::InDataW-1:0]  s_tdata,   // vcell_raw[15:0], soc_raw[31:16]
  input  logic                          s_tuser,   // read_ok
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bcte_pkg::OutDataW-1:0] m_tdata,   // voltage_code[11:0], charge_q8[26:12],
                                                   // trend_code[28:27], confidence[35:29]
  output logic                          m_tuser,   // available
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bcte_pkg::CfgDataW-1:0] cfg_data
);
  import bcte_pkg::*;

  localparam int IdxW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FillW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IdxW-1:0]  LastSlot = IdxW'(HISTORY_DEPTH - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(HISTORY_DEPTH);

  logic [ChargeW-1:0] soc_thr;
  logic [VoltW-1:0]   volt_thr;
  logic [ChargeW-1:0] charge_hist [HISTORY_DEPTH];
  logic [VoltW-1:0]   volt_hist   [HISTORY_DEPTH];
  logic [IdxW-1:0]    write_slot, write_slot_next, oldest_slot;
  logic [FillW-1:0]   fill_count;

  logic [VoltW-1:0]   out_volt;
  logic [ChargeW-1:0] out_charge;
  trend_code_t        out_state;
  logic [ConfW-1:0]   out_conf;
  logic               out_avail;

  logic               accept, read_ok, rising;
  logic [15:0]        vcell_raw, soc_raw;
  logic [VoltW-1:0]   vcode;
  logic [ChargeW-1:0] charge;
  logic [ChargeW:0]   charge_lim;
  logic [VoltW:0]     volt_lim;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign read_ok   = s_tuser;
  assign vcell_raw = s_tdata[15:0];
  assign soc_raw   = s_tdata[31:16];

  assign vcode  = vcell_raw[15:4];
  assign charge = (soc_raw > {1'b0, ChargeFullQ8}) ? ChargeFullQ8 : soc_raw[ChargeW-1:0];

  assign write_slot_next = (write_slot == LastSlot) ? '0 : write_slot + 1'b1;
  assign oldest_slot     = write_slot_next;

  // rise above threshold: new > old + thr, one bit wider so the sum cannot wrap
  assign charge_lim = {1'b0, charge_hist[oldest_slot]} + {1'b0, soc_thr};
  assign volt_lim   = {1'b0, volt_hist[oldest_slot]} + {1'b0, volt_thr};
  assign rising     = ({1'b0, charge} > charge_lim) || ({1'b0, vcode} > volt_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      soc_thr  <= 15'd38;
      volt_thr <= 12'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        RegSocRiseThr:  soc_thr  <= cfg_data;
        RegVoltRiseThr: volt_thr <= cfg_data[VoltW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (accept && read_ok) begin
      write_slot <= write_slot_next;
      if (fill_count != FillFull) fill_count <= fill_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && read_ok) begin
      charge_hist[write_slot] <= charge;
      volt_hist[write_slot]   <= vcode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (s_tready) m_tvalid <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!read_ok) begin
        out_avail  <= 1'b0;
        out_volt   <= '0;
        out_charge <= '0;
        out_state  <= StateUnknown;
        out_conf   <= ConfNone;
      end else begin
        out_avail  <= 1'b1;
        out_volt   <= vcode;
        out_charge <= charge;
        if (fill_count != FillFull) begin
          out_state <= StateUnknown;
          out_conf  <= ConfUnknown;
        end else if (rising) begin
          out_state <= StateCharging;
          out_conf  <= ConfCharging;
        end else begin
          out_state <= StateNotCharging;
          out_conf  <= ConfNotCharging;
        end
      end
    end
  end

  assign m_tuser = out_avail;
  assign m_tdata = {4'd0, out_conf, out_state, out_charge, out_volt};

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FillFull) else $error("fill count beyond history depth");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot <= LastSlot) else $error("write slot beyond history depth");

  a_fail_keeps_state: assert property (@(posedge clk) disable iff (rst)
    accept && !read_ok |=> $stable(write_slot) && $stable(fill_count))
    else $error("failed read changed history state");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid) else $error("accepted request produced no result");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> out_conf == ConfNone && out_state == StateUnknown)
    else $error("failed read result not cleared");
`endif

endmodule

// ----- tb/sv/tb_battery_charge_trend_estimator.sv -----
// Self-checking testbench for battery_charge_trend_estimator.
// Drives fuel-gauge samples through the stream ports and checks each result against
// a local predictor or a row's fixed value; depends on bcte_pkg and the block's RTL.
module tb_battery_charge_trend_estimator;
  import bcte_pkg::*;

  localparam int Depth         = HistoryDepthDefault;
  localparam int IdleLimit     = 3000;
  localparam int SinkHoldCycles = 200;
  localparam int ItemsPerPhase = 70;
  localparam int NumPhases     = 7;

  typedef struct packed {
    logic                available;
    logic [VoltW-1:0]    voltage_code;
    logic [ChargeW-1:0]  charge_q8;
    trend_code_t         trend_code;
    logic [ConfW-1:0]    confidence;
  } trend_result_t;

  typedef struct {
    bit            ok;
    logic [15:0]   vcell;
    logic [15:0]   soc;
    bit            typed;
    trend_result_t want;
  } sample_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;   // vcell_raw[15:0], soc_raw[31:16]
  logic                s_tuser = 1'b0; // read_ok
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;        // voltage_code[11:0], charge_q8[26:12],
                                       // trend_code[28:27], confidence[35:29]
  logic                m_tuser;        // available
  logic                cfg_we = 1'b0;
  logic                cfg_index = RegSocRiseThr;
  logic [CfgDataW-1:0] cfg_data = '0;

  // predictor state
  logic [ChargeW-1:0] charge_ring [Depth];
  logic [VoltW-1:0]   volt_ring [Depth];
  int                 ring_slot = 0;
  int                 ring_fill = 0;
  logic [ChargeW-1:0] soc_thr_q = 15'd38;
  logic [VoltW-1:0]   volt_thr_q = 12'd12;

  trend_result_t expected_trend [$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  bit            sink_hold = 1'b0;
  int            level_v = 2000;
  int            level_c = 12800;

  sample_row_t directed_rows [15] = '{
    '{1'b0, 16'hFFFF, 16'hFFFF, 1'b1, '{1'b0, 12'h000, 15'd0, StateUnknown, ConfNone}},
    '{1'b1, 16'h0000, 16'h0000, 1'b1, '{1'b1, 12'h000, 15'd0, StateUnknown, ConfUnknown}},
    '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, '{1'b1, 12'hFFF, 15'd25600, StateUnknown, ConfUnknown}},
    '{1'b1, 16'h000F, 16'h6400, 1'b1, '{1'b1, 12'h000, 15'd25600, StateUnknown, ConfUnknown}},
    '{1'b1, 16'h8000, 16'h6401, 1'b1, '{1'b1, 12'h800, 15'd25600, StateUnknown, ConfUnknown}},
    '{1'b0, 16'h0000, 16'h0000, 1'b1, '{1'b0, 12'h000, 15'd0, StateUnknown, ConfNone}},
    '{1'b1, 16'h1230, 16'h3201, 1'b1, '{1'b1, 12'h123, 15'h3201, StateUnknown, ConfUnknown}},
    '{1'b1, 16'h4560, 16'h1000, 1'b1, '{1'b1, 12'h456, 15'h1000, StateUnknown, ConfUnknown}},
    // ring now full: fall, voltage rise, rises exactly at and just over threshold
    '{1'b1, 16'h0000, 16'h0000, 1'b0, '0},
    '{1'b1, 16'h00D0, 16'h0000, 1'b0, '0},
    '{1'b1, 16'h80C0, 16'hFFFF, 1'b0, '0},
    '{1'b1, 16'h1230, 16'h3227, 1'b0, '0},
    '{1'b1, 16'h4560, 16'h1027, 1'b0, '0},
    '{1'b0, 16'hABCD, 16'h1234, 1'b1, '{1'b0, 12'h000, 15'd0, StateUnknown, ConfNone}},
    '{1'b1, 16'h7FFF, 16'h7FFF, 1'b0, '0}
  };

  battery_charge_trend_estimator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic trend_result_t predict_trend(bit ok, logic [15:0] vcell,
                                                  logic [15:0] soc);
    trend_result_t      res;
    logic [ChargeW-1:0] charge;
    logic [VoltW-1:0]   vcode;
    int                 oldest;
    int                 dq;
    int                 dv;
    res = '{1'b0, '0, '0, StateUnknown, ConfNone};
    if (!ok) return res;
    vcode  = vcell[15:4];
    charge = (soc > 16'(ChargeFullQ8)) ? ChargeFullQ8 : soc[ChargeW-1:0];
    charge_ring[ring_slot] = charge;
    volt_ring[ring_slot]   = vcode;
    res.available    = 1'b1;
    res.voltage_code = vcode;
    res.charge_q8    = charge;
    if (ring_fill < Depth) begin
      ring_fill++;
      res.trend_code = StateUnknown;
      res.confidence = ConfUnknown;
    end else begin
      oldest = (ring_slot + 1 >= Depth) ? 0 : ring_slot + 1;
      dq = int'(charge) - int'(charge_ring[oldest]);
      dv = int'(vcode) - int'(volt_ring[oldest]);
      if (dq > int'(soc_thr_q) || dv > int'(volt_thr_q)) begin
        res.trend_code = StateCharging;
        res.confidence = ConfCharging;
      end else begin
        res.trend_code = StateNotCharging;
        res.confidence = ConfNotCharging;
      end
    end
    ring_slot = (ring_slot + 1 >= Depth) ? 0 : ring_slot + 1;
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_sample(bit ok, logic [15:0] vcell, logic [15:0] soc, bit typed,
                             trend_result_t want, bit burst);
    trend_result_t pred;
    int            gap;
    s_tuser  <= ok;
    s_tdata  <= {soc, vcell};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pred = predict_trend(ok, vcell, soc);
    expected_trend.push_back(typed ? want : pred);
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(bit burst);
    int          r;
    bit          ok;
    logic [15:0] vcell;
    logic [15:0] soc;
    r  = $urandom_range(0, 99);
    ok = 1'b1;
    level_v += $urandom_range(0, 10) - 4;
    level_c += $urandom_range(0, 30) - 12;
    if (level_v < 0) level_v = 0;
    if (level_v > 4095) level_v = 4095;
    if (level_c < 0) level_c = 0;
    if (level_c > 25600) level_c = 25600;
    vcell = {level_v[11:0], 4'($urandom)};
    soc   = level_c[15:0];
    if (r < 8) begin
      ok    = 1'b0;
      vcell = 16'($urandom);
      soc   = 16'($urandom);
    end else if (r < 18) begin
      vcell = 16'($urandom);
      soc   = 16'($urandom);
    end else if (r < 25) begin
      soc = 16'($urandom_range(25601, 65535));
    end
    send_sample(ok, vcell, soc, 1'b0, '0, burst);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_trend.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_thresholds(logic [CfgDataW-1:0] soc_val,
                                  logic [CfgDataW-1:0] volt_val);
    cfg_we    <= 1'b1;
    cfg_index <= RegSocRiseThr;
    cfg_data  <= soc_val;
    @(posedge clk);
    soc_thr_q = soc_val;
    cfg_index <= RegVoltRiseThr;
    cfg_data  <= volt_val;
    @(posedge clk);
    volt_thr_q = volt_val[VoltW-1:0];
    cfg_we <= 1'b0;
  endtask

  task automatic report_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    trend_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_trend.size() == 0) begin
        $display("%0t: result with no request outstanding, got %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = expected_trend.pop_front();
        report_field("available", want.available, m_tuser);
        report_field("voltage_code", want.voltage_code, m_tdata[11:0]);
        report_field("charge_q8", want.charge_q8, m_tdata[26:12]);
        report_field("trend_code", want.trend_code, m_tdata[28:27]);
        report_field("confidence", want.confidence, m_tdata[35:29]);
      end
    end
  end

  // watchdog on stretches with no request moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_trend.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random ready pattern, long hold-off on request
  initial begin
    int run;
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (sink_hold) begin
        m_tready <= 1'b0;
        repeat (SinkHoldCycles) @(posedge clk);
        sink_hold = 1'b0;
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
        gap = pick_gap();
        m_tready <= 1'b1;
        repeat (run) @(posedge clk);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [CfgDataW-1:0] soc_set;
    logic [CfgDataW-1:0] volt_set;
    bit                  burst;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset thresholds
    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].ok, directed_rows[i].vcell, directed_rows[i].soc,
                  directed_rows[i].typed, directed_rows[i].want, 1'b0);
    end
    drain();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin soc_set = 15'd0;     volt_set = 15'd0;    end
        1: begin soc_set = 15'd25600; volt_set = 15'd4095; end
        2: begin soc_set = 15'd0;     volt_set = 15'd4095; end
        3: begin soc_set = 15'd25600; volt_set = 15'd0;    end
        // upper data bits beyond the voltage register width are dropped
        4: begin
          soc_set  = 15'($urandom_range(0, 80));
          volt_set = 15'h7000 | 15'($urandom_range(0, 30));
        end
        default: begin
          soc_set  = 15'($urandom_range(0, 80));
          volt_set = 15'($urandom_range(0, 30));
        end
      endcase
      write_thresholds(soc_set, volt_set);
      // fill up the block against a stalled receiver
      if (phase == 2) sink_hold = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        burst = (phase == 2 && n < 30) || (phase == 5 && n >= 20 && n < 50);
        send_random(burst);
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_trend.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/bcte_pkg.sv
sv/battery_charge_trend_estimator.sv
tb/sv/tb_battery_charge_trend_estimator.sv
